// ===== rtl/core/wft_pkg.sv =====
`timescale 1ns / 1ps

package wft_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int WORD_CHARS    = 8;
    localparam int COUNT_BITS    = 16;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int ENT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int LEN_W  = $clog2(WORD_CHARS + 1);
    localparam int WORD_W = 8 * WORD_CHARS;

    localparam logic [7:0] CHAR_LOW  = 8'd65;   // 'A'
    localparam logic [7:0] CHAR_HIGH = 8'd122;  // 'z'

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic RESULT_WORD    = 1'b0;
    localparam logic RESULT_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CMP,
        ST_MIN_ADDR,
        ST_MIN_CMP,
        ST_SUM
    } wft_state_t;

    typedef struct packed {
        logic in_accept;
        logic scan_clr;
        logic scan_inc;
        logic commit_new;
        logic commit_hit;
        logic min_step;
        logic load_sum;
    } wft_cmd_t;

    typedef struct packed {
        logic word_ends;
        logic in_last;
        logic last_reg;
        logic at_end;
        logic hit;
        logic out_free;
        logic tbl_empty;
        logic min_last;
    } wft_sts_t;

endpackage

// ===== rtl/core/wft_ctrl.sv =====
`timescale 1ns / 1ps

module wft_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  wft_pkg::wft_sts_t sts,
    output wft_pkg::wft_cmd_t cmd
);
    import wft_pkg::*;

    wft_state_t state_reg;
    wft_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (sts.word_ends)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else if (sts.in_last)
                    begin
                        state_next = ST_MIN_ADDR;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (!sts.at_end)
                begin
                    state_next = ST_CMP;
                end
                else if (sts.out_free)
                begin
                    state_next = sts.last_reg ? ST_MIN_ADDR : ST_IDLE;
                end
            end
            ST_CMP:
            begin
                if (!sts.hit)
                begin
                    state_next = ST_SEARCH;
                end
                else if (sts.out_free)
                begin
                    state_next = sts.last_reg ? ST_MIN_ADDR : ST_IDLE;
                end
            end
            ST_MIN_ADDR:
            begin
                state_next = sts.tbl_empty ? ST_SUM : ST_MIN_CMP;
            end
            ST_MIN_CMP:
            begin
                state_next = sts.min_last ? ST_SUM : ST_MIN_ADDR;
            end
            ST_SUM:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.in_accept = in_valid;
                cmd.scan_clr  = in_valid;
            end
            ST_SEARCH:
            begin
                // past the last used slot: insert or drop once the output frees
                if (sts.at_end && sts.out_free)
                begin
                    cmd.commit_new = 1'b1;
                    cmd.scan_clr   = 1'b1;
                end
            end
            ST_CMP:
            begin
                if (!sts.hit)
                begin
                    cmd.scan_inc = 1'b1;
                end
                else if (sts.out_free)
                begin
                    cmd.commit_hit = 1'b1;
                    cmd.scan_clr   = 1'b1;
                end
            end
            ST_MIN_ADDR:
            begin
            end
            ST_MIN_CMP:
            begin
                cmd.min_step = 1'b1;
                cmd.scan_inc = 1'b1;
            end
            ST_SUM:
            begin
                cmd.load_sum = sts.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/core/wft_dp.sv =====
`timescale 1ns / 1ps

module wft_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wft_pkg::wft_cmd_t                 cmd,
    output wft_pkg::wft_sts_t                 sts,
    input  logic [7:0]                        text_byte,
    input  logic                              end_of_text,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              result_kind,
    output logic [wft_pkg::IDX_W-1:0]         entry_index,
    output logic [wft_pkg::COUNT_BITS-1:0]    occurrences,
    output logic                              newly_added,
    output logic                              table_full_drop,
    output logic                              word_truncated,
    output logic [wft_pkg::IDX_W-1:0]         least_index,
    output logic [wft_pkg::COUNT_BITS-1:0]    least_count,
    output logic                              last_result
);
    import wft_pkg::*;

    // table stores
    logic [WORD_W-1:0]     word_mem  [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] count_mem [TABLE_ENTRIES];
    logic [WORD_W-1:0]     word_rd_reg;
    logic [COUNT_BITS-1:0] count_rd_reg;

    // word assembly
    logic [WORD_W-1:0] word_buf_reg,  word_buf_next;
    logic [LEN_W-1:0]  word_len_reg,  word_len_next;
    logic              overlong_reg,  overlong_next;
    logic              last_reg;
    logic              word_char;

    logic [ENT_W-1:0]      entries_reg;
    logic [ENT_W-1:0]      scan_reg;
    logic [COUNT_BITS-1:0] top_count_reg;
    logic [IDX_W-1:0]      top_index_reg;
    logic [COUNT_BITS-1:0] lcnt_reg;
    logic [IDX_W-1:0]      lidx_reg;

    logic                  out_valid_reg;
    logic                  kind_reg;
    logic [IDX_W-1:0]      index_reg;
    logic [COUNT_BITS-1:0] occ_reg;
    logic                  added_reg;
    logic                  drop_reg;
    logic                  trunc_reg;
    logic [IDX_W-1:0]      least_index_reg;
    logic [COUNT_BITS-1:0] least_count_reg;
    logic                  last_result_reg;

    logic [IDX_W-1:0]      slot;
    logic                  tbl_full;
    logic                  do_insert;
    logic                  do_drop;
    logic [COUNT_BITS-1:0] new_count;
    logic                  top_better;
    logic                  out_free;
    logic                  tbl_empty;

    always_comb
    begin
        word_char     = (text_byte >= CHAR_LOW) && (text_byte <= CHAR_HIGH);
        word_buf_next = word_buf_reg;
        word_len_next = word_len_reg;
        overlong_next = overlong_reg;
        if (word_char)
        begin
            if (word_len_reg < LEN_W'(WORD_CHARS))
            begin
                for (int i = 0; i < WORD_CHARS; i++)
                begin
                    if (word_len_reg == LEN_W'(i))
                    begin
                        word_buf_next[8*i +: 8] = text_byte;
                    end
                end
                word_len_next = word_len_reg + 1'b1;
            end
            else
            begin
                overlong_next = 1'b1;
            end
        end
    end

    assign slot      = scan_reg[IDX_W-1:0];
    assign tbl_full  = (entries_reg == ENT_W'(TABLE_ENTRIES));
    assign tbl_empty = (entries_reg == '0);
    assign do_insert = cmd.commit_new && !tbl_full;
    assign do_drop   = cmd.commit_new && tbl_full;
    assign out_free  = !out_valid_reg || out_ready;

    // a fresh entry starts at one; a hit saturates at the top of the range
    always_comb
    begin
        if (cmd.commit_hit)
        begin
            new_count = (count_rd_reg == COUNT_MAX) ? count_rd_reg
                                                    : count_rd_reg + 1'b1;
        end
        else
        begin
            new_count = COUNT_BITS'(1);
        end
    end

    assign top_better = (new_count > top_count_reg) ||
                        ((new_count == top_count_reg) && (slot < top_index_reg));

    always_comb
    begin
        sts           = '0;
        sts.word_ends = (!word_char || end_of_text) && (word_len_next != '0);
        sts.in_last   = end_of_text;
        sts.last_reg  = last_reg;
        sts.at_end    = (scan_reg == entries_reg);
        sts.hit       = (word_rd_reg == word_buf_reg);
        sts.out_free  = out_free;
        sts.tbl_empty = tbl_empty;
        sts.min_last  = ((scan_reg + 1'b1) == entries_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_buf_reg  <= '0;
            word_len_reg  <= '0;
            overlong_reg  <= 1'b0;
            last_reg      <= 1'b0;
            entries_reg   <= '0;
            scan_reg      <= '0;
            top_count_reg <= '0;
            top_index_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.in_accept)
            begin
                word_buf_reg <= word_buf_next;
                word_len_reg <= word_len_next;
                overlong_reg <= overlong_next;
                last_reg     <= end_of_text;
            end
            else if (cmd.commit_new || cmd.commit_hit || cmd.load_sum)
            begin
                word_buf_reg <= '0;
                word_len_reg <= '0;
                overlong_reg <= 1'b0;
            end

            if (cmd.scan_clr)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_inc)
            begin
                scan_reg <= scan_reg + 1'b1;
            end

            if (do_insert)
            begin
                entries_reg <= entries_reg + 1'b1;
            end
            else if (cmd.load_sum)
            begin
                entries_reg <= '0;
            end

            if ((do_insert || cmd.commit_hit) && top_better)
            begin
                top_count_reg <= new_count;
                top_index_reg <= slot;
            end
            else if (cmd.load_sum)
            begin
                top_count_reg <= '0;
                top_index_reg <= '0;
            end

            if (cmd.commit_new || cmd.commit_hit || cmd.load_sum)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // stores: one write port, one registered read port at the scan slot
    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            word_mem[slot] <= word_buf_reg;
        end
        if (do_insert || cmd.commit_hit)
        begin
            count_mem[slot] <= new_count;
        end
        word_rd_reg  <= word_mem[slot];
        count_rd_reg <= count_mem[slot];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.min_step)
        begin
            if ((scan_reg == '0) || (count_rd_reg < lcnt_reg))
            begin
                lcnt_reg <= count_rd_reg;
                lidx_reg <= slot;
            end
        end

        if (cmd.commit_new || cmd.commit_hit)
        begin
            kind_reg        <= RESULT_WORD;
            index_reg       <= do_drop ? '0 : slot;
            occ_reg         <= do_drop ? '0 : new_count;
            added_reg       <= do_insert;
            drop_reg        <= do_drop;
            trunc_reg       <= overlong_reg;
            least_index_reg <= '0;
            least_count_reg <= '0;
            last_result_reg <= !last_reg;
        end
        else if (cmd.load_sum)
        begin
            kind_reg        <= RESULT_SUMMARY;
            index_reg       <= top_index_reg;
            occ_reg         <= top_count_reg;
            added_reg       <= 1'b0;
            drop_reg        <= 1'b0;
            trunc_reg       <= 1'b0;
            least_index_reg <= tbl_empty ? '0 : lidx_reg;
            least_count_reg <= tbl_empty ? '0 : lcnt_reg;
            last_result_reg <= 1'b1;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign entry_index     = index_reg;
    assign occurrences     = occ_reg;
    assign newly_added     = added_reg;
    assign table_full_drop = drop_reg;
    assign word_truncated  = trunc_reg;
    assign least_index     = least_index_reg;
    assign least_count     = least_count_reg;
    assign last_result     = last_result_reg;

endmodule

// ===== rtl/core/word_frequency_table_core.sv =====
`timescale 1ns / 1ps

// Word frequency counter. Text arrives one byte per item; bytes 'A'..'z' build
// a word of up to 8 characters (longer words are matched on their first 8 and
// flagged), any other byte ends it. Each word end yields one result with the
// word's table slot, its saturating count and insert/drop/truncate flags; the
// byte marked end_of_text adds a summary of the most and least repeated slots
// and empties the table. A word end scans the table through the single
// registered read port of the stores, passing through a search and a compare
// state for each used entry; the end of text adds a minimum scan with an
// address and a compare state per used entry (an empty table skips to the
// summary). A result that waits for out_ready stalls the next result until
// it leaves; bytes are still taken while the block is idle. The stores need
// no clearing after reset: only slots below the fill count are read.
module word_frequency_table_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     text_byte,
    input  logic                           end_of_text,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           result_kind,
    output logic [wft_pkg::IDX_W-1:0]      entry_index,
    output logic [wft_pkg::COUNT_BITS-1:0] occurrences,
    output logic                           newly_added,
    output logic                           table_full_drop,
    output logic                           word_truncated,
    output logic [wft_pkg::IDX_W-1:0]      least_index,
    output logic [wft_pkg::COUNT_BITS-1:0] least_count,
    output logic                           last_result
);
    import wft_pkg::*;

    wft_cmd_t cmd;
    wft_sts_t sts;

    wft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wft_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .text_byte       (text_byte),
        .end_of_text     (end_of_text),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .result_kind     (result_kind),
        .entry_index     (entry_index),
        .occurrences     (occurrences),
        .newly_added     (newly_added),
        .table_full_drop (table_full_drop),
        .word_truncated  (word_truncated),
        .least_index     (least_index),
        .least_count     (least_count),
        .last_result     (last_result)
    );

endmodule
